// File: design/ppp_hdlc_pkg.sv
package ppp_hdlc_pkg;

   // Line codes
   localparam logic [7:0] FLAG_BYTE = 8'h7e;
   localparam logic [7:0] ESC_BYTE  = 8'h7d;
   localparam logic [7:0] ESC_XOR   = 8'h20;
   localparam logic [7:0] ADDR_BYTE = 8'hff;
   localparam logic [7:0] CTRL_BYTE = 8'h03;

   // FCS-16, reflected
   localparam logic [15:0] FCS_INIT = 16'hffff;
   localparam logic [15:0] FCS_GOOD = 16'hf0b8;
   localparam logic [15:0] FCS_POLY = 16'h8408;

   localparam int STATUS_W = 3;
   localparam int LENGTH_W = 12;

   // Frame status codes
   localparam logic [STATUS_W-1:0] ST_GOOD     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FCS  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERLONG = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   // Operation passed from the front to the back
   typedef struct packed {
      logic       is_flag;     // closing flag
      logic       esc_pending; // escape dropped at this flag
      logic [7:0] data;        // decoded byte
   } op_type;

   // One byte step of the FCS
   function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] acc;
      acc = fcs ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ FCS_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

// File: design/ppp_hdlc_if.sv
interface ppp_hdlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ppp_hdlc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               is_frame_end;
   logic [7:0]                         data_byte;
   logic [ppp_hdlc_pkg::STATUS_W-1:0]  frame_status;
   logic [ppp_hdlc_pkg::LENGTH_W-1:0]  payload_length;
   modport source (output valid, output is_frame_end, output data_byte,
                   output frame_status, output payload_length, input ready);
   modport sink (input valid, input is_frame_end, input data_byte,
                 input frame_status, input payload_length, output ready);
endinterface

interface ppp_hdlc_csr_if;
   logic valid;
   logic ready;
   logic strip_address_control;
   modport source (output valid, output strip_address_control, input ready);
   modport sink (input valid, input strip_address_control, output ready);
endinterface

// File: design/ppp_async_hdlc_deframer_unit.sv
// Throughput: one line byte per cycle, sustained while rsp_chan.ready stays high.
// A closing flag reaches its end transfer through the front decode into a
// two-entry queue, then the back FCS/length stage into the result register;
// payload bytes come out two decoded bytes behind the line.
// Reset (synchronous, active high): hunt for the first flag, FCS at 0xffff,
// queue and result register empty, address/control strip option set to 1.
module ppp_async_hdlc_deframer_unit #(
   parameter int MAX_FRAME = 2048
) (
   input  logic              clock,
   input  logic              reset,
   ppp_hdlc_req_if.sink      req_chan,
   ppp_hdlc_rsp_if.source    rsp_chan,
   ppp_hdlc_csr_if.sink      csr_chan
);

   logic                  strip_cfg_ff, strip_cfg_in;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   ppp_hdlc_pkg::op_type  q_in_op;
   ppp_hdlc_pkg::op_type  q_head_op;

   // Configuration register write
   assign csr_chan.ready = 1'b1;
   assign strip_cfg_in   = (csr_chan.valid && csr_chan.ready) ?
                           csr_chan.strip_address_control : strip_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_cfg_ff <= 1'b1;
      end else begin
         strip_cfg_ff <= strip_cfg_in;
      end
   end

   ppp_hdlc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_op     (q_in_op)
   );

   ppp_hdlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_in_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (q_head_op)
   );

   ppp_hdlc_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .strip_cfg  (strip_cfg_ff),
      .head_valid (q_valid),
      .head_op    (q_head_op),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: design/ppp_hdlc_front.sv
module ppp_hdlc_front (
   input  logic                  clock,
   input  logic                  reset,
   ppp_hdlc_req_if.sink          req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output ppp_hdlc_pkg::op_type  q_op
);

   logic in_frame_ff, in_frame_in;
   logic esc_ff, esc_in;
   logic accept;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;

   // Hunt for the first flag, undo escapes and classify each byte
   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      q_push      = 1'b0;
      q_op        = '0;
      if (accept) begin
         if (req_chan.rx_byte == ppp_hdlc_pkg::FLAG_BYTE) begin
            if (in_frame_ff) begin
               q_push           = 1'b1;
               q_op.is_flag     = 1'b1;
               q_op.esc_pending = esc_ff;
            end
            in_frame_in = 1'b1;
            esc_in      = 1'b0;
         end else if (in_frame_ff) begin
            if (esc_ff) begin
               q_push    = 1'b1;
               q_op.data = req_chan.rx_byte ^ ppp_hdlc_pkg::ESC_XOR;
               esc_in    = 1'b0;
            end else if (req_chan.rx_byte == ppp_hdlc_pkg::ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               q_push    = 1'b1;
               q_op.data = req_chan.rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
      end
   end

endmodule

// File: design/ppp_hdlc_queue.sv
module ppp_hdlc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ppp_hdlc_pkg::op_type  push_op,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ppp_hdlc_pkg::op_type  head_op
);

   ppp_hdlc_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: design/ppp_hdlc_back.sv
module ppp_hdlc_back #(
   parameter int MAX_FRAME = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  strip_cfg,
   input  logic                  head_valid,
   input  ppp_hdlc_pkg::op_type  head_op,
   output logic                  pop,
   ppp_hdlc_rsp_if.source        rsp_chan
);

   localparam logic [ppp_hdlc_pkg::LENGTH_W-1:0] MaxCount =
      ppp_hdlc_pkg::LENGTH_W'(MAX_FRAME);

   logic [15:0]                        fcs_ff, fcs_in;
   logic [ppp_hdlc_pkg::LENGTH_W-1:0]  count_ff, count_in;
   logic [7:0]                         d0_ff, d0_in, d1_ff, d1_in;
   logic                               strip_ff, strip_in;
   logic                               over_ff, over_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_end_ff, rsp_end_in;
   logic [7:0]                         rsp_data_ff, rsp_data_in;
   logic [ppp_hdlc_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ppp_hdlc_pkg::LENGTH_W-1:0]  rsp_len_ff, rsp_len_in;

   logic [ppp_hdlc_pkg::LENGTH_W-1:0]  len_raw;
   logic [ppp_hdlc_pkg::LENGTH_W-1:0]  len_net;
   logic                               strip_now;

   assign pop = head_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.is_frame_end   = rsp_end_ff;
   assign rsp_chan.data_byte      = rsp_data_ff;
   assign rsp_chan.frame_status   = rsp_status_ff;
   assign rsp_chan.payload_length = rsp_len_ff;

   // Payload length at the closing flag, FCS and stripped pair removed
   assign len_raw = count_ff - ppp_hdlc_pkg::LENGTH_W'(2);
   assign len_net = strip_ff ? (len_raw - ppp_hdlc_pkg::LENGTH_W'(2)) : len_raw;

   // Address and control pair seen in the delay line at the third byte
   assign strip_now = strip_ff ||
                      ((count_ff == ppp_hdlc_pkg::LENGTH_W'(2)) && strip_cfg &&
                       (d0_ff == ppp_hdlc_pkg::ADDR_BYTE) &&
                       (d1_ff == ppp_hdlc_pkg::CTRL_BYTE));

   // Carry out one operation per transfer from the queue
   always_comb begin
      fcs_in        = fcs_ff;
      count_in      = count_ff;
      d0_in         = d0_ff;
      d1_in         = d1_ff;
      strip_in      = strip_ff;
      over_in       = over_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_end_in    = rsp_end_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      if (pop) begin
         if (head_op.is_flag) begin
            // Close the frame and report unless it was empty
            if (count_ff != '0 || head_op.esc_pending || over_ff) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = 1'b1;
               rsp_data_in  = 8'h00;
               rsp_len_in   = '0;
               if (over_ff) begin
                  rsp_status_in = ppp_hdlc_pkg::ST_OVERLONG;
               end else if (count_ff < ppp_hdlc_pkg::LENGTH_W'(4)) begin
                  rsp_status_in = ppp_hdlc_pkg::ST_SHORT;
               end else if (fcs_ff != ppp_hdlc_pkg::FCS_GOOD) begin
                  rsp_status_in = ppp_hdlc_pkg::ST_BAD_FCS;
               end else if (strip_ff && len_net < ppp_hdlc_pkg::LENGTH_W'(2)) begin
                  rsp_status_in = ppp_hdlc_pkg::ST_EMPTY;
               end else begin
                  rsp_status_in = ppp_hdlc_pkg::ST_GOOD;
                  rsp_len_in    = len_net;
               end
            end
            fcs_in   = ppp_hdlc_pkg::FCS_INIT;
            count_in = '0;
            d0_in    = 8'h00;
            d1_in    = 8'h00;
            strip_in = 1'b0;
            over_in  = 1'b0;
         end else if (!over_ff) begin
            if (count_ff >= MaxCount) begin
               over_in = 1'b1;
            end else begin
               fcs_in   = ppp_hdlc_pkg::fcs_step(fcs_ff, head_op.data);
               strip_in = strip_now;
               d0_in    = d1_ff;
               d1_in    = head_op.data;
               count_in = count_ff + ppp_hdlc_pkg::LENGTH_W'(1);
               // Release the byte leaving the delay line
               if (count_ff >= ppp_hdlc_pkg::LENGTH_W'(2) &&
                   !(strip_now && count_ff < ppp_hdlc_pkg::LENGTH_W'(4))) begin
                  rsp_valid_in  = 1'b1;
                  rsp_end_in    = 1'b0;
                  rsp_data_in   = d0_ff;
                  rsp_status_in = ppp_hdlc_pkg::ST_GOOD;
                  rsp_len_in    = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcs_ff       <= ppp_hdlc_pkg::FCS_INIT;
         count_ff     <= '0;
         d0_ff        <= 8'h00;
         d1_ff        <= 8'h00;
         strip_ff     <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fcs_ff       <= fcs_in;
         count_ff     <= count_in;
         d0_ff        <= d0_in;
         d1_ff        <= d1_in;
         strip_ff     <= strip_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_end_ff    <= rsp_end_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

endmodule

// File: bench/ppp_hdlc_deframer_checker.sv
`timescale 1ns / 1ps

module ppp_hdlc_deframer_checker #(
   parameter int MAX_FRAME = 2048
) (
   input  logic   clock,
   input  logic   reset,
   ppp_hdlc_req_if req_chan,
   ppp_hdlc_rsp_if rsp_chan,
   ppp_hdlc_csr_if csr_chan,
   output int     fail_count,
   output int     pending_count,
   output int     end_count,
   output int     payload_count
);

   typedef struct packed {
      logic                              is_frame_end;
      logic [7:0]                        data_byte;
      logic [ppp_hdlc_pkg::STATUS_W-1:0] frame_status;
      logic [ppp_hdlc_pkg::LENGTH_W-1:0] payload_length;
   } deframer_item_type;

   // Results still owed by the block, oldest first
   deframer_item_type frame_items_due[$];

   // Shadow of the deframer state
   logic        strip_cfg;
   logic        in_frame;
   logic        esc_pending;
   logic [15:0] fcs_acc;
   int unsigned frame_bytes;
   logic [7:0]  delay_q [2];
   logic        strip_active;
   logic        overlong_seen;

   // Advance the reflected CRC one bit at a time, LSB first
   function automatic logic [15:0] fcs_advance(input logic [15:0] acc, input logic [7:0] c);
      logic [15:0] crc;
      crc = acc;
      for (int k = 0; k < 8; k++) begin
         crc = (crc[0] ^ c[k]) ? ((crc >> 1) ^ ppp_hdlc_pkg::FCS_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   function automatic void clear_frame();
      esc_pending   = 1'b0;
      fcs_acc       = ppp_hdlc_pkg::FCS_INIT;
      frame_bytes   = 0;
      delay_q[0]    = 8'h00;
      delay_q[1]    = 8'h00;
      strip_active  = 1'b0;
      overlong_seen = 1'b0;
   endfunction

   // Work out what one line byte gives and queue it
   task automatic decode_line_byte(input logic [7:0] b);
      deframer_item_type item;
      logic [7:0]        c;
      logic [7:0]        leaving;
      logic              have_byte;
      logic              emit;
      int                len;
      item = '0;
      if (b == ppp_hdlc_pkg::FLAG_BYTE) begin
         if (!in_frame) begin
            // first flag ends the hunt
            in_frame = 1'b1;
            clear_frame();
         end else if (frame_bytes == 0 && !esc_pending && !overlong_seen) begin
            // back-to-back flags: nothing to report
            clear_frame();
         end else begin
            len = 0;
            if (overlong_seen) begin
               item.frame_status = ppp_hdlc_pkg::ST_OVERLONG;
            end else if (frame_bytes < 4) begin
               item.frame_status = ppp_hdlc_pkg::ST_SHORT;
            end else if (fcs_acc != ppp_hdlc_pkg::FCS_GOOD) begin
               item.frame_status = ppp_hdlc_pkg::ST_BAD_FCS;
            end else begin
               len = int'(frame_bytes) - 2 - (strip_active ? 2 : 0);
               if (strip_active && len < 2) begin
                  item.frame_status = ppp_hdlc_pkg::ST_EMPTY;
                  len = 0;
               end else begin
                  item.frame_status = ppp_hdlc_pkg::ST_GOOD;
               end
            end
            item.is_frame_end   = 1'b1;
            item.payload_length = ppp_hdlc_pkg::LENGTH_W'(len);
            frame_items_due.push_back(item);
            clear_frame();
         end
      end else if (in_frame) begin
         // undo byte stuffing
         have_byte = 1'b1;
         c = b;
         if (esc_pending) begin
            esc_pending = 1'b0;
            c = b ^ ppp_hdlc_pkg::ESC_XOR;
         end else if (b == ppp_hdlc_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
            have_byte = 1'b0;
         end
         if (have_byte && !overlong_seen) begin
            if (frame_bytes >= MAX_FRAME) begin
               // freeze count and FCS until the closing flag
               overlong_seen = 1'b1;
            end else begin
               leaving = delay_q[0];
               if (frame_bytes == 2 && strip_cfg &&
                   delay_q[0] == ppp_hdlc_pkg::ADDR_BYTE &&
                   delay_q[1] == ppp_hdlc_pkg::CTRL_BYTE) begin
                  strip_active = 1'b1;
               end
               emit = (frame_bytes >= 2) && !(strip_active && frame_bytes < 4);
               fcs_acc = fcs_advance(fcs_acc, c);
               delay_q[0] = delay_q[1];
               delay_q[1] = c;
               frame_bytes++;
               if (emit) begin
                  item.data_byte = leaving;
                  frame_items_due.push_back(item);
               end
            end
         end
      end
   endtask

   function automatic void compare_field(input string field, input logic [15:0] exp_v,
                                         input logic [15:0] got_v);
      if (got_v !== exp_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, got_v);
      end
   endfunction

   // Track configuration and line transfers, then check the result transfer
   always @(posedge clock) begin
      deframer_item_type due;
      if (reset) begin
         strip_cfg = 1'b1;
         in_frame  = 1'b0;
         clear_frame();
         frame_items_due.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            strip_cfg = csr_chan.strip_address_control;
         end
         if (req_chan.valid && req_chan.ready) begin
            decode_line_byte(req_chan.rx_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (rsp_chan.is_frame_end === 1'b1) begin
               end_count++;
            end else begin
               payload_count++;
            end
            if (frame_items_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none,", $time,
                        " actual end=%0b data=0x%0h status=%0d length=%0d",
                        rsp_chan.is_frame_end, rsp_chan.data_byte,
                        rsp_chan.frame_status, rsp_chan.payload_length);
            end else begin
               due = frame_items_due.pop_front();
               compare_field("is_frame_end", 16'(due.is_frame_end), 16'(rsp_chan.is_frame_end));
               compare_field("data_byte", 16'(due.data_byte), 16'(rsp_chan.data_byte));
               compare_field("frame_status", 16'(due.frame_status), 16'(rsp_chan.frame_status));
               compare_field("payload_length", 16'(due.payload_length),
                             16'(rsp_chan.payload_length));
            end
         end
      end
      pending_count = frame_items_due.size();
   end

endmodule

// File: bench/tb_ppp_async_hdlc_deframer_unit.sv
`timescale 1ns / 1ps

module tb_ppp_async_hdlc_deframer_unit;

   localparam int MAX_FRAME = 2048;
   localparam int PHASE_BYTES = 120;

   typedef enum int {
      FK_GOOD,
      FK_BAD_FCS,
      FK_SHORT,
      FK_ESC_FLAG,
      FK_NOISE,
      FK_FLAGS
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready = 1'b0;

   int send_idle_pct = 19;
   int recv_idle_pct = 77;
   int bytes_sent = 0;

   int fail_count;
   int pending_count;
   int end_count;
   int payload_count;

   // Decoded bytes of the frame being built
   logic [7:0] frame_body[$];

   ppp_hdlc_req_if req_chan ();
   ppp_hdlc_rsp_if rsp_chan ();
   ppp_hdlc_csr_if csr_chan ();

   assign rsp_chan.ready = rsp_ready;

   ppp_async_hdlc_deframer_unit #(
      .MAX_FRAME(MAX_FRAME)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ppp_hdlc_deframer_checker #(
      .MAX_FRAME(MAX_FRAME)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_chan      (csr_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .end_count     (end_count),
      .payload_count (payload_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Throttle the result side
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Timeout: results still outstanding or a handshake stuck");
      $display("RESULT: ERROR");
      $finish;
   end

   // FCS over the body, for building well-formed frames
   function automatic logic [15:0] body_fcs();
      logic [15:0] crc;
      crc = ppp_hdlc_pkg::FCS_INIT;
      foreach (frame_body[i]) begin
         for (int k = 0; k < 8; k++) begin
            crc = (crc[0] ^ frame_body[i][k]) ?
                  ((crc >> 1) ^ ppp_hdlc_pkg::FCS_POLY) : (crc >> 1);
         end
      end
      return crc;
   endfunction

   // Mostly uniform bytes, with line codes and header values mixed in
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 7) != 0) begin
         return 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 6))
         0: return ppp_hdlc_pkg::FLAG_BYTE;
         1: return ppp_hdlc_pkg::ESC_BYTE;
         2: return ppp_hdlc_pkg::ADDR_BYTE;
         3: return ppp_hdlc_pkg::CTRL_BYTE;
         4: return ppp_hdlc_pkg::FLAG_BYTE ^ ppp_hdlc_pkg::ESC_XOR;
         5: return ppp_hdlc_pkg::ESC_BYTE ^ ppp_hdlc_pkg::ESC_XOR;
         default: return 8'h00;
      endcase
   endfunction

   // Present one line byte; returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stuff one decoded byte; escape the odd harmless byte as well
   task automatic send_decoded(input logic [7:0] c);
      if (c == ppp_hdlc_pkg::FLAG_BYTE || c == ppp_hdlc_pkg::ESC_BYTE ||
          (c != (ppp_hdlc_pkg::FLAG_BYTE ^ ppp_hdlc_pkg::ESC_XOR) &&
           $urandom_range(0, 15) == 0)) begin
         send_byte(ppp_hdlc_pkg::ESC_BYTE);
         send_byte(c ^ ppp_hdlc_pkg::ESC_XOR);
      end else begin
         send_byte(c);
      end
   endtask

   // Send the body, optionally with FCS, a corrupted byte or a dangling escape
   task automatic send_frame_body(input logic with_fcs, input logic corrupt,
                                  input logic trailing_escape);
      logic [15:0] crc;
      int          idx;
      crc = ~body_fcs();
      if (corrupt && frame_body.size() != 0) begin
         idx = $urandom_range(0, frame_body.size() - 1);
         frame_body[idx] = frame_body[idx] ^ 8'($urandom_range(1, 255));
      end
      foreach (frame_body[i]) begin
         send_decoded(frame_body[i]);
      end
      if (with_fcs) begin
         send_decoded(crc[7:0]);
         send_decoded(crc[15:8]);
      end
      if (trailing_escape) begin
         send_byte(ppp_hdlc_pkg::ESC_BYTE);
      end
      send_byte(ppp_hdlc_pkg::FLAG_BYTE);
   endtask

   // Hold the line quiet until every result is in, then let the pipe settle
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_strip(input logic strip);
      csr_chan.valid                 <= 1'b1;
      csr_chan.strip_address_control <= strip;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_random_frame();
      frame_kind_type kind;
      int             pick;
      int             len;
      pick = $urandom_range(0, 99);
      kind = (pick < 55) ? FK_GOOD :
             (pick < 70) ? FK_BAD_FCS :
             (pick < 80) ? FK_SHORT :
             (pick < 88) ? FK_ESC_FLAG :
             (pick < 94) ? FK_NOISE : FK_FLAGS;
      frame_body.delete();
      // address/control pair, sometimes a near miss
      if ($urandom_range(0, 1) != 0) begin
         frame_body.push_back(ppp_hdlc_pkg::ADDR_BYTE);
         frame_body.push_back(ppp_hdlc_pkg::CTRL_BYTE);
      end else if ($urandom_range(0, 9) == 0) begin
         frame_body.push_back(ppp_hdlc_pkg::ADDR_BYTE);
         frame_body.push_back(pick_byte());
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (len) frame_body.push_back(pick_byte());
      case (kind)
         FK_GOOD: send_frame_body(1'b1, 1'b0, 1'b0);
         FK_BAD_FCS: begin
            if (frame_body.size() == 0) frame_body.push_back(pick_byte());
            send_frame_body(1'b1, 1'b1, 1'b0);
         end
         FK_SHORT: begin
            len = $urandom_range(0, 3);
            while (frame_body.size() > len) void'(frame_body.pop_back());
            send_frame_body(1'b0, 1'b0, 1'b0);
         end
         FK_ESC_FLAG: begin
            len = $urandom_range(0, 6);
            while (frame_body.size() > len) void'(frame_body.pop_back());
            send_frame_body(1'b0, 1'b0, 1'b1);
         end
         FK_NOISE: begin
            repeat ($urandom_range(1, 6)) send_byte(pick_byte());
         end
         default: begin
            repeat ($urandom_range(1, 3)) send_byte(ppp_hdlc_pkg::FLAG_BYTE);
         end
      endcase
   endtask

   initial begin
      int phase_start;
      req_chan.valid                 <= 1'b0;
      req_chan.rx_byte               <= 8'h00;
      csr_chan.valid                 <= 1'b0;
      csr_chan.strip_address_control <= 1'b1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_strip(1'b1);

      // Junk before the first flag is ignored
      send_byte(8'h00);
      send_byte(ppp_hdlc_pkg::ADDR_BYTE);
      send_byte(ppp_hdlc_pkg::ESC_BYTE);
      // Opening flag, then an empty frame
      send_byte(ppp_hdlc_pkg::FLAG_BYTE);
      send_byte(ppp_hdlc_pkg::FLAG_BYTE);
      // Only the address/control pair: empty once stripped
      frame_body = '{ppp_hdlc_pkg::ADDR_BYTE, ppp_hdlc_pkg::CTRL_BYTE};
      send_frame_body(1'b1, 1'b0, 1'b0);
      // Frame holding a lone escape dropped at the flag
      send_byte(ppp_hdlc_pkg::ESC_BYTE);
      send_byte(ppp_hdlc_pkg::FLAG_BYTE);
      // Escape code after an escape, still too short
      send_byte(ppp_hdlc_pkg::ESC_BYTE);
      send_byte(ppp_hdlc_pkg::ESC_BYTE);
      send_byte(8'h41);
      send_byte(ppp_hdlc_pkg::FLAG_BYTE);
      // Corrupted body: bad FCS
      frame_body = '{8'h00, 8'hff};
      send_frame_body(1'b1, 1'b1, 1'b0);
      // Good frame with stuffed flag and escape codes in the payload
      frame_body = '{ppp_hdlc_pkg::ADDR_BYTE, ppp_hdlc_pkg::CTRL_BYTE,
                     ppp_hdlc_pkg::FLAG_BYTE, ppp_hdlc_pkg::ESC_BYTE};
      send_frame_body(1'b1, 1'b0, 1'b0);

      // Random traffic under three flow-control mixes
      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         write_strip(phase == 1);
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 77 : 0;
         recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 19 : 0;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            send_random_frame();
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
      end

      wait_drained();
      $display("Covered %0d line bytes over three flow-control mixes and both strip settings,",
               bytes_sent);
      $display("checking %0d frame ends and %0d payload bytes; %0d mismatches.",
               end_count, payload_count, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
